// File: rtl/core/tsw_pkg.sv
// Shared types and constants for the top-four skin weight selector.
package tsw_pkg;

    // Width of the slot number field on the result stream.
    localparam int SLOT_W = 2;

    // Slot bank controls driven by the sequencer.
    typedef struct packed {
        logic take;    // insert or replace with the incoming influence
        logic shift;   // move every slot down by one, zero the top slot
        logic finish;  // vertex done: drop fill count and running sum
    } t_bank_ctl;

    // Divider start request.
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Divider status.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: rtl/core/top4_skin_weight_select.sv
// Top level: influence intake, slot sequencing and result output register.
//
// Input stream carries one bone influence per request: tdata holds the bone
// index (low bits) and the weight (2^FRAC_BITS is 1.0), tlast marks the final
// influence of a vertex. Weights above 1.0 are clamped on entry.
// Output stream carries SLOTS requests per vertex: slot number, bone and
// weight in tdata, tlast on the final slot.
// After an influence without tlast, tready stays high. After a final
// influence, each slot passes the start and push states, with a run of the
// bit-serial divider between them when the slot sum lies strictly between
// zero and 1.0; the weight is then divided by that sum, else it passes
// through unchanged.
// The input is not ready while a vertex is being emitted. The output register
// holds a result until it is taken; a stall there halts the slot sequence.
// The last result may still wait while the next vertex's influences arrive.
// Synchronous reset clears the slots, the fill count, the running sum and
// drops the output valid flag; the block is ready the cycle after reset.
module top4_skin_weight_select import tsw_pkg::*; #(
    parameter int SLOTS     = 4,
    parameter int BONE_BITS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // bone_index, weight
    input  logic [((BONE_BITS+FRAC_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                     i_s_axis_tlast,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // slot, bone, norm_weight
    output logic [((SLOT_W+BONE_BITS+FRAC_BITS+1+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                     o_m_axis_tlast
);

    localparam int SUM_W = FRAC_BITS + 1 + $clog2(SLOTS);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int K_W   = (IDX_W < SLOT_W) ? SLOT_W : IDX_W;
    localparam int OUT_W = SLOT_W + BONE_BITS + FRAC_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam logic [FRAC_BITS:0] ONE_FIX = (FRAC_BITS+1)'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_DIV   = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [K_W-1:0]       r_k;
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [BONE_BITS-1:0] r_out_bone;
    logic [FRAC_BITS:0]   r_out_wt;
    logic                 r_out_last;

    t_bank_ctl            bank_ctl;
    t_div_ctl             div_ctl;
    t_div_stat            div_stat;
    logic [BONE_BITS-1:0] head_bone;
    logic [FRAC_BITS:0]   head_wt;
    logic [SUM_W-1:0]     sum;
    logic [FRAC_BITS:0]   quot;

    logic                 s_acc;
    logic [FRAC_BITS:0]   w_in;
    logic [FRAC_BITS:0]   w_sat;
    logic                 norm;
    logic                 out_free;
    logic                 push_fire;
    logic                 k_last;
    logic [FRAC_BITS:0]   res_wt;

    always_comb begin
        s_acc     = i_s_axis_tvalid && (r_state == S_IDLE);
        w_in      = i_s_axis_tdata[BONE_BITS +: FRAC_BITS+1];
        w_sat     = (w_in > ONE_FIX) ? ONE_FIX : w_in;
        norm      = (sum != '0) && (sum < SUM_W'(ONE_FIX));
        out_free  = !r_out_valid || i_m_axis_tready;
        push_fire = (r_state == S_PUSH) && out_free;
        k_last    = (r_k == K_W'(SLOTS - 1));
        res_wt    = norm ? quot : head_wt;

        bank_ctl.take   = s_acc;
        bank_ctl.shift  = push_fire;
        bank_ctl.finish = push_fire && k_last;
        div_ctl.start   = (r_state == S_START) && norm;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_axis_tlast) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = norm ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = k_last ? S_IDLE : S_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push_fire) begin
                r_k         <= k_last ? '0 : r_k + K_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the payload until the next slot is pushed
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_out_slot <= r_k[SLOT_W-1:0];
            r_out_bone <= head_bone;
            r_out_wt   <= res_wt;
            r_out_last <= k_last;
        end
    end

    tsw_slot_bank #(
        .SLOTS     (SLOTS),
        .BONE_BITS (BONE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (bank_ctl),
        .i_bone        (i_s_axis_tdata[BONE_BITS-1:0]),
        .i_weight      (w_sat),
        .o_head_bone   (head_bone),
        .o_head_weight (head_wt),
        .o_sum         (sum)
    );

    tsw_bit_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (head_wt),
        .i_den   (sum[FRAC_BITS-1:0]),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_wt, r_out_bone, r_out_slot});
    assign o_m_axis_tlast  = r_out_last;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside of the divide state");

    a_no_take_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_s_axis_tready)
        else $error("input ready while the divider is busy");

    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> (r_state == S_START))
        else $error("final influence did not start the slot sequence");

    a_tlast_on_final_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_fire && k_last) |=> (o_m_axis_tvalid && o_m_axis_tlast && r_k == '0))
        else $error("final slot not marked or slot counter not rewound");

endmodule

// File: rtl/core/tsw_slot_bank.sv
// Slot bank: keeps the strongest influences of a vertex and a running weight sum.
module tsw_slot_bank import tsw_pkg::*; #(
    parameter int SLOTS     = 4,
    parameter int BONE_BITS = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_bank_ctl                                i_ctl,
    input  logic [BONE_BITS-1:0]                     i_bone,
    input  logic [FRAC_BITS:0]                       i_weight,
    output logic [BONE_BITS-1:0]                     o_head_bone,
    output logic [FRAC_BITS:0]                       o_head_weight,
    output logic [FRAC_BITS+$clog2(SLOTS):0]         o_sum
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SUM_W = FRAC_BITS + 1 + $clog2(SLOTS);

    logic [BONE_BITS-1:0] r_bone [SLOTS];
    logic [FRAC_BITS:0]   r_wt   [SLOTS];
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;

    logic [IDX_W-1:0]     low_idx;
    logic [FRAC_BITS:0]   low_wt;
    logic                 full;

    // Find the first slot holding the lowest weight.
    always_comb begin
        low_idx = '0;
        for (int k = 1; k < SLOTS; k++) begin
            if (r_wt[k] < r_wt[low_idx]) begin
                low_idx = IDX_W'(k);
            end
        end
        low_wt = r_wt[low_idx];
        full   = (r_count == CNT_W'(SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_bone[i] <= '0;
                r_wt[i]   <= '0;
            end
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_ctl.take) begin
            if (!full) begin
                r_bone[r_count[IDX_W-1:0]] <= i_bone;
                r_wt[r_count[IDX_W-1:0]]   <= i_weight;
                r_count                    <= r_count + CNT_W'(1);
                r_sum                      <= r_sum + SUM_W'(i_weight);
            end else if (i_weight > low_wt) begin
                r_bone[low_idx] <= i_bone;
                r_wt[low_idx]   <= i_weight;
                r_sum           <= r_sum + SUM_W'(i_weight) - SUM_W'(low_wt);
            end
        end else if (i_ctl.shift) begin
            // advance the next slot to the head, refill the top with zero
            for (int i = 0; i < SLOTS; i++) begin
                if (i == SLOTS - 1) begin
                    r_bone[i] <= '0;
                    r_wt[i]   <= '0;
                end else begin
                    r_bone[i] <= r_bone[(i + 1) % SLOTS];
                    r_wt[i]   <= r_wt[(i + 1) % SLOTS];
                end
            end
            if (i_ctl.finish) begin
                r_count <= '0;
                r_sum   <= '0;
            end
        end
    end

    assign o_head_bone   = r_bone[0];
    assign o_head_weight = r_wt[0];
    assign o_sum         = r_sum;

endmodule

// File: rtl/core/tsw_bit_div.sv
// Bit-serial restoring divider: one quotient bit per cycle for weight renormalization.
module tsw_bit_div import tsw_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_ctl             i_ctl,
    input  logic [FRAC_BITS:0]   i_num,
    input  logic [FRAC_BITS-1:0] i_den,
    output t_div_stat            o_stat,
    output logic [FRAC_BITS:0]   o_quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [FRAC_BITS:0] r_rem;
    logic [FRAC_BITS:0] r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic               ge;
    logic [FRAC_BITS:0] diff;

    // numerator is at most the divisor, so each difference stays below it
    always_comb begin
        ge   = (r_rem >= {1'b0, i_den});
        diff = ge ? (r_rem - {1'b0, i_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS + 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num;
        end else if (r_busy) begin
            r_rem  <= {diff[FRAC_BITS-1:0], 1'b0};
            r_quot <= {r_quot[FRAC_BITS-1:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule
